/* rtl/nps_pkg.sv */
package nps_pkg;

    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_COORD_BITS = 16;

    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int DIST_W  = 33;
    localparam int SUM_W   = DIST_W + 2;

    localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};
    localparam logic [SUM_W-1:0]  SQ_LIMIT  = SUM_W'(35'h17FFF);

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_MX,
        S_MY,
        S_CMP,
        S_DONE
    } t_state;

endpackage

/* rtl/nps_point_store.sv */
module nps_point_store #(
    parameter int DEPTH  = nps_pkg::DEF_MAX_POINTS,
    parameter int DATA_W = nps_pkg::DEF_COORD_BITS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_x,
    input  logic [DATA_W-1:0] i_wr_y,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_x,
    output logic [DATA_W-1:0] o_rd_y
);

    logic [2*DATA_W-1:0] r_mem [DEPTH];
    logic [2*DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_x, i_wr_y};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_x = r_rd_data[2*DATA_W-1:DATA_W];
    assign o_rd_y = r_rd_data[DATA_W-1:0];

endmodule

/* rtl/nearest_point_search.sv */
// Load word: written to the table at the accept edge, no result.
// Query word: scans n = min(point_count, MAX_POINTS) entries, then presents the result;
// one shared squarer serves both axes, each entry stepping through DIFF, MX, MY and CMP.
// Ready only while idle; an ended search holds while the previous result waits.
// Reset (i_rst_n low, synchronous) clears control, result valid and point_count;
// table contents are undefined until loaded.
module nearest_point_search #(
    parameter int MAX_POINTS = nps_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = nps_pkg::DEF_COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [nps_pkg::COUNT_W-1:0]   i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_req_type,
    input  logic [nps_pkg::INDEX_W-1:0]   i_entry_index,
    input  logic signed [COORD_BITS-1:0]  i_coord_x,
    input  logic signed [COORD_BITS-1:0]  i_coord_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_found,
    output logic [nps_pkg::INDEX_W-1:0]   o_nearest_index,
    output logic [nps_pkg::DIST_W-1:0]    o_nearest_dist_sq
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int D_W   = COORD_BITS + 1;
    localparam int P_W   = 2 * D_W;

    nps_pkg::t_state r_state, n_state;

    logic [nps_pkg::COUNT_W-1:0] r_point_count;
    logic signed [COORD_BITS-1:0] r_qx, r_qy;
    logic [IDX_W-1:0] r_idx, r_last, r_best_i;
    logic r_any;
    logic [nps_pkg::DIST_W-1:0] r_best_d;
    logic [D_W-1:0] r_dx, r_dy;
    logic [nps_pkg::SUM_W-1:0] r_sqx, r_sqy;

    logic r_out_valid, r_out_found;
    logic [nps_pkg::INDEX_W-1:0] r_out_index;
    logic [nps_pkg::DIST_W-1:0] r_out_dist;

    logic w_accept, w_query, w_load, w_empty, w_out_load, w_last_hit, w_better;
    logic [IDX_W-1:0] w_wr_addr, w_rd_addr, w_last;
    logic [COORD_BITS-1:0] w_rd_x, w_rd_y;
    logic signed [D_W-1:0] w_ax, w_ay, w_bx, w_by;
    logic [D_W-1:0] w_dx, w_dy, w_op;
    logic [P_W-1:0] w_prod;
    logic [nps_pkg::SUM_W-1:0] w_sq, w_sum;
    logic [nps_pkg::DIST_W-1:0] w_d;

    assign w_accept = i_valid && o_ready;
    assign w_query  = w_accept && (i_req_type == nps_pkg::REQ_QUERY);
    assign w_load   = w_accept && (i_req_type == nps_pkg::REQ_LOAD)
                      && (32'(i_entry_index) < 32'(MAX_POINTS));
    assign w_wr_addr = IDX_W'(i_entry_index);
    assign w_rd_addr = (r_state == nps_pkg::S_CMP) ? IDX_W'(r_idx + 1'b1) : '0;

    assign w_empty = (r_point_count == '0);
    assign w_last  = (32'(r_point_count) > 32'(MAX_POINTS)) ? IDX_W'(MAX_POINTS - 1)
                                                            : IDX_W'(r_point_count - 1'b1);

    nps_point_store #(
        .DEPTH  (MAX_POINTS),
        .DATA_W (COORD_BITS),
        .ADDR_W (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_load),
        .i_wr_addr (w_wr_addr),
        .i_wr_x    (i_coord_x),
        .i_wr_y    (i_coord_y),
        .i_rd_addr (w_rd_addr),
        .o_rd_x    (w_rd_x),
        .o_rd_y    (w_rd_y)
    );

    assign w_ax = D_W'($signed(w_rd_x));
    assign w_ay = D_W'($signed(w_rd_y));
    assign w_bx = D_W'(r_qx);
    assign w_by = D_W'(r_qy);
    assign w_dx = (w_ax >= w_bx) ? D_W'(w_ax - w_bx) : D_W'(w_bx - w_ax);
    assign w_dy = (w_ay >= w_by) ? D_W'(w_ay - w_by) : D_W'(w_by - w_ay);

    assign w_op   = (r_state == nps_pkg::S_MX) ? r_dx : r_dy;
    assign w_prod = P_W'(w_op) * P_W'(w_op);
    assign w_sq   = (64'(w_op) > 64'(nps_pkg::SQ_LIMIT))
                    ? nps_pkg::SUM_W'(nps_pkg::DIST_MAX) : nps_pkg::SUM_W'(w_prod);

    assign w_sum  = r_sqx + r_sqy;
    assign w_d    = (w_sum > nps_pkg::SUM_W'(nps_pkg::DIST_MAX))
                    ? nps_pkg::DIST_MAX : nps_pkg::DIST_W'(w_sum);
    assign w_better   = !r_any || (w_d < r_best_d);
    assign w_last_hit = (r_idx == r_last);

    always_comb begin
        n_state = r_state;
        case (r_state)
            nps_pkg::S_IDLE: begin
                if (w_query) begin
                    n_state = w_empty ? nps_pkg::S_DONE : nps_pkg::S_DIFF;
                end
            end
            nps_pkg::S_DIFF: n_state = nps_pkg::S_MX;
            nps_pkg::S_MX:   n_state = nps_pkg::S_MY;
            nps_pkg::S_MY:   n_state = nps_pkg::S_CMP;
            nps_pkg::S_CMP: begin
                n_state = w_last_hit ? nps_pkg::S_DONE : nps_pkg::S_DIFF;
            end
            nps_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = nps_pkg::S_IDLE;
                end
            end
            default: n_state = nps_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready    = (r_state == nps_pkg::S_IDLE);
        w_out_load = (r_state == nps_pkg::S_DONE) && (!r_out_valid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= nps_pkg::S_IDLE;
            r_point_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_point_count <= i_cfg_wr_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_qx     <= i_coord_x;
            r_qy     <= i_coord_y;
            r_last   <= w_last;
            r_idx    <= '0;
            r_any    <= 1'b0;
            r_best_i <= '0;
            r_best_d <= '0;
        end
        case (r_state)
            nps_pkg::S_DIFF: begin
                r_dx <= w_dx;
                r_dy <= w_dy;
            end
            nps_pkg::S_MX: r_sqx <= w_sq;
            nps_pkg::S_MY: r_sqy <= w_sq;
            nps_pkg::S_CMP: begin
                if (w_better) begin
                    r_any    <= 1'b1;
                    r_best_d <= w_d;
                    r_best_i <= r_idx;
                end
                r_idx <= IDX_W'(r_idx + 1'b1);
            end
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_out_found <= r_any;
            r_out_index <= nps_pkg::INDEX_W'(r_best_i);
            r_out_dist  <= r_best_d;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_found           = r_out_found;
    assign o_nearest_index   = r_out_index;
    assign o_nearest_dist_sq = r_out_dist;

`ifndef SYNTHESIS
    a_done_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> o_valid)
        else $error("result not presented after search end");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nps_pkg::S_DIFF || r_state == nps_pkg::S_MX
         || r_state == nps_pkg::S_MY || r_state == nps_pkg::S_CMP) |-> (r_idx <= r_last))
        else $error("scan index beyond last entry");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_nearest_index == '0 && o_nearest_dist_sq == '0))
        else $error("empty search returned nonzero fields");
`endif

endmodule
